/* sv/assert_macros.svh */
// assertion macros, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/rsa_pkg.sv */
package rsa_pkg;
  typedef struct packed {
    logic [15:0] prime_p;
    logic [15:0] prime_q;
    logic [31:0] message;
  } rsa_in_t;

  typedef struct packed {
    logic [31:0] modulus;
    logic [31:0] public_exp;
    logic [31:0] private_exp;
    logic [31:0] ciphertext;
    logic [31:0] recovered;
    logic [1:0]  status;
  } rsa_out_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NO_E  = 2'd1;
  localparam logic [1:0] ST_NO_D  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_EINIT, OP_ESTEP, OP_DINIT, OP_DSTEP,
    OP_DFIX, OP_CTINIT, OP_RECINIT, OP_PSTEP, OP_DSTART, OP_RSTART, OP_MSTART
  } rsa_op_t;

  typedef struct packed {
    rsa_op_t op;
  } rsa_cmd_t;

  typedef struct packed {
    logic done;
    logic t_small;
    logic e_found;
    logic e_fail;
    logic d_done;
    logic d_ok;
    logic exp_done;
    logic n_zero;
  } rsa_stat_t;
endpackage

/* sv/rsa_div.sv */
module rsa_div #(
  parameter int W  = 32,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [W-1:0]  divisor,
  output logic          done,
  output logic [W-1:0]  rem,
  output logic [DW-1:0] quo
);
  localparam int CW = $clog2(DW+1);
  logic [W:0]     rem_r, rem_nxt;
  logic [DW-1:0]  quo_r, quo_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]     sh;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = {rem_r[W-1:0], quo_r[DW-1]};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DW-2:0], 1'b0};
      if (sh >= {1'b0, divisor}) begin
        rem_nxt = sh - {1'b0, divisor};
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = sh;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[W-1:0];
  assign quo  = quo_r;
endmodule

/* sv/rsa_datapath.sv */
module rsa_datapath #(
  parameter int MOD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rsa_pkg::rsa_in_t  in_data,
  input  rsa_pkg::rsa_cmd_t cmd,
  output rsa_pkg::rsa_stat_t stat,
  output rsa_pkg::rsa_out_t out_data
);
  import rsa_pkg::*;
  localparam int W = MOD_BITS;
  localparam int DW = (2 * W > 32) ? 2 * W : 32;

  logic [15:0]  p_r, q_r;
  logic [31:0]  msg_r;
  logic [W-1:0] n_r, t_r, e_r, j_r;
  logic signed [W+1:0] r0_r, r1_r, s0_r, s1_r;
  logic [W-1:0] base_r, acc_r, ct_r, rec_r, d_r;
  logic [W-1:0] ex_r;
  logic [1:0]   ph_r;
  logic         ddone_r, dok_r, xdone_r;
  logic         run_r, src_msg_r;

  logic         dv_start;
  logic [DW-1:0] dv_a;
  logic [W-1:0] dv_b, dv_rem;
  logic [DW-1:0] dv_quo;
  logic         dv_done;
  logic [31:0]  pm, qm;
  logic [63:0]  prod_n, prod_t;
  logic [2*W-1:0] prod_ab, prod_bb;
  logic signed [2*W+3:0] qs;

  rsa_div #(.W(W), .DW(DW)) u_div (
    .clk, .rst_n, .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .rem(dv_rem), .quo(dv_quo)
  );

  assign pm = {16'd0, p_r - 16'd1};
  assign qm = {16'd0, q_r - 16'd1};
  assign prod_n = {32'd0, 16'd0, p_r} * {32'd0, 16'd0, q_r};
  assign prod_t = {32'd0, pm} * {32'd0, qm};
  assign prod_ab = {{W{1'b0}}, acc_r} * {{W{1'b0}}, base_r};
  assign prod_bb = {{W{1'b0}}, base_r} * {{W{1'b0}}, base_r};
  assign qs = $signed({2'b00, dv_quo[W+1:0]}) * s1_r;

  always_comb begin
    dv_start = 1'b0;
    dv_a = '0;
    dv_b = n_r;
    unique case (cmd.op)
      OP_ESTEP: begin
        dv_start = 1'b1; dv_a = DW'(t_r); dv_b = j_r;
      end
      OP_DSTEP: begin
        dv_start = 1'b1; dv_a = DW'(r0_r[W-1:0]); dv_b = r1_r[W-1:0];
      end
      OP_MSTART: begin
        dv_start = 1'b1; dv_a = src_msg_r ? DW'(msg_r) : DW'(base_r);
      end
      OP_PSTEP: begin
        dv_start = 1'b1;
        if (ph_r == 2'd0) dv_a = DW'(prod_ab);
        else if (ph_r == 2'd1) dv_a = DW'(prod_bb);
      end
      default: ;
    endcase
    if (run_r) dv_start = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ddone_r <= 1'b0;
      dok_r   <= 1'b0;
      xdone_r <= 1'b0;
      ph_r    <= '0;
      run_r   <= 1'b0;
    end else begin
      ddone_r <= 1'b0;
      xdone_r <= 1'b0;
      if (dv_done) run_r <= 1'b0;
      else if (dv_start) run_r <= 1'b1;
      unique case (cmd.op)
        OP_LOAD: begin
          p_r <= in_data.prime_p; q_r <= in_data.prime_q; msg_r <= in_data.message;
        end
        OP_MUL: begin
          n_r <= prod_n[W-1:0]; t_r <= prod_t[W-1:0];
          e_r <= '0; d_r <= '0; ct_r <= '0; rec_r <= '0;
        end
        OP_EINIT: j_r <= W'(2);
        OP_ESTEP: ;
        OP_DINIT: begin
          r0_r <= $signed({2'b00, t_r}); r1_r <= $signed({2'b00, e_r});
          s0_r <= '0; s1_r <= (W+2)'(1);
        end
        OP_DSTEP: ;
        OP_DFIX: ;
        OP_CTINIT: begin
          src_msg_r <= 1'b1; ex_r <= e_r;
        end
        OP_RECINIT: begin
          base_r <= ct_r; ex_r <= d_r; src_msg_r <= 1'b0;
        end
        OP_MSTART: ph_r <= 2'd3;
        OP_PSTEP: ;
        default: ;
      endcase
      if (dv_done) begin
        unique case (cmd.op)
          OP_ESTEP: begin
            if (dv_rem != '0) e_r <= j_r;
            else j_r <= j_r + 1'b1;
          end
          OP_DSTEP: begin
            r0_r <= r1_r;
            r1_r <= $signed({2'b00, dv_rem});
            s0_r <= s1_r;
            s1_r <= s0_r - qs[W+1:0];
            if (dv_rem == '0) begin
              ddone_r <= 1'b1;
              dok_r <= (r1_r == (W+2)'(1));
            end
          end
          OP_PSTEP: begin
            if (ph_r == 2'd3) begin
              base_r <= dv_rem; acc_r <= (n_r <= W'(1)) ? '0 : W'(1);
              ph_r <= ex_r[0] ? 2'd0 : 2'd1;
              if (ex_r == '0) xdone_r <= 1'b1;
            end else if (ph_r == 2'd0) begin
              acc_r <= dv_rem; ph_r <= 2'd1;
            end else begin
              base_r <= dv_rem; ex_r <= ex_r >> 1;
              if ((ex_r >> 1) == '0) xdone_r <= 1'b1;
              ph_r <= ex_r[1] ? 2'd0 : 2'd1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.op == OP_DFIX)
        d_r <= s0_r[W+1] ? W'(s0_r + $signed({2'b00, t_r})) : s0_r[W-1:0];
      if (cmd.op == OP_DSTART) ct_r <= acc_r;
      if (cmd.op == OP_RSTART) rec_r <= acc_r;
      if (cmd.op == OP_NONE && ph_r != 2'd3 && xdone_r) ph_r <= ph_r;
    end
  end

  always_comb begin
    stat = '0;
    stat.done     = dv_done;
    stat.t_small  = (t_r < W'(3));
    stat.e_found  = dv_done && cmd.op == OP_ESTEP && dv_rem != '0;
    stat.e_fail   = (j_r >= t_r);
    stat.d_done   = ddone_r;
    stat.d_ok     = dok_r;
    stat.exp_done = xdone_r;
    stat.n_zero   = (n_r == '0);
  end

  always_comb begin
    out_data = '0;
    out_data.modulus     = 32'(n_r);
    out_data.public_exp  = 32'(e_r);
    out_data.private_exp = 32'(d_r);
    out_data.ciphertext  = 32'(ct_r);
    out_data.recovered   = 32'(rec_r);
  end
endmodule

/* sv/rsa_ctrl.sv */
`include "assert_macros.svh"
module rsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rsa_pkg::rsa_stat_t stat,
  output rsa_pkg::rsa_cmd_t  cmd,
  output logic               busy,
  output logic               fin,
  output logic [1:0]         fin_status
);
  import rsa_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ECHK, S_EGO, S_EWAIT, S_DINIT, S_DGO, S_DWAIT,
    S_CTSET, S_XGO, S_XWAIT, S_DFIX, S_RECSET, S_FIN
  } state_t;

  state_t     st_r;
  logic       rec_r, dok_r;
  logic [1:0] sts_r;
  logic       fin_r;

  always_comb begin
    cmd.op = OP_NONE;
    unique case (st_r)
      S_IDLE:   cmd.op = start ? OP_LOAD : OP_NONE;
      S_MUL:    cmd.op = OP_MUL;
      S_ECHK:   cmd.op = OP_EINIT;
      S_EGO:    cmd.op = OP_ESTEP;
      S_EWAIT:  cmd.op = OP_ESTEP;
      S_DINIT:  cmd.op = OP_DINIT;
      S_DGO:    cmd.op = OP_DSTEP;
      S_DWAIT:  cmd.op = OP_DSTEP;
      S_CTSET:  cmd.op = rec_r ? OP_RECINIT : OP_CTINIT;
      S_XGO:    cmd.op = OP_MSTART;
      S_XWAIT:  cmd.op = stat.exp_done ? (rec_r ? OP_RSTART : OP_DSTART) : OP_PSTEP;
      S_DFIX:   cmd.op = OP_DFIX;
      S_RECSET: cmd.op = OP_NONE;
      S_FIN:    cmd.op = OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      rec_r <= 1'b0;
      dok_r <= 1'b0;
      sts_r <= ST_OK;
      fin_r <= 1'b0;
    end else begin
      fin_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (start) st_r <= S_MUL;
        S_MUL:  st_r <= S_ECHK;
        S_ECHK: begin
          rec_r <= 1'b0;
          if (stat.t_small) begin
            sts_r <= ST_NO_E; st_r <= S_FIN;
          end else st_r <= S_EGO;
        end
        S_EGO: st_r <= S_EWAIT;
        S_EWAIT: if (stat.done) begin
          if (stat.e_found) st_r <= S_DINIT;
          else st_r <= S_EGO;
        end
        S_DINIT: st_r <= S_DGO;
        S_DGO:   st_r <= S_DWAIT;
        S_DWAIT: if (stat.done) st_r <= S_RECSET;
        S_RECSET: begin
          if (stat.d_done) begin
            dok_r <= stat.d_ok; st_r <= S_DFIX;
          end else st_r <= S_DGO;
        end
        S_DFIX: st_r <= S_CTSET;
        S_CTSET: st_r <= S_XGO;
        S_XGO:   st_r <= S_XWAIT;
        S_XWAIT: if (stat.exp_done) begin
          if (!rec_r && dok_r) begin
            rec_r <= 1'b1; st_r <= S_CTSET;
          end else begin
            sts_r <= dok_r ? ST_OK : ST_NO_D; st_r <= S_FIN;
          end
        end
        S_FIN: begin
          fin_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (st_r != S_IDLE);
  assign fin = fin_r;
  assign fin_status = sts_r;

  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_IMPL(a_fin_idle, clk, rst_n, fin, !busy)
  `ASSERT_NEXT(a_fin_pulse, clk, rst_n, fin, !fin)
endmodule

/* sv/toy_rsa_key_and_cipher.sv */
// run time is data dependent, set by the exponent search, the inverse and the two
// exponentiations sharing one bit-serial divider; a totient below three skips them all
// start is taken only in idle, so a new key setup waits for the previous result
// busy high until the result beat; no stall possible
// synchronous active-low reset returns the controller to idle
`include "assert_macros.svh"
module toy_rsa_key_and_cipher #(
  parameter int MOD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rsa_pkg::rsa_in_t  in_data,
  output logic              out_valid,
  output rsa_pkg::rsa_out_t out_data
);
  import rsa_pkg::*;
  rsa_cmd_t   cmd;
  rsa_stat_t  stat;
  rsa_out_t   dp_out;
  logic       fin;
  logic [1:0] fin_status;
  logic [1:0] s;

  rsa_ctrl u_ctrl (
    .clk, .rst_n, .start, .stat, .cmd, .busy, .fin, .fin_status
  );

  rsa_datapath #(.MOD_BITS(MOD_BITS)) u_dp (
    .clk, .rst_n, .in_data, .cmd, .stat, .out_data(dp_out)
  );

  assign s = fin_status;
  always_comb begin
    out_data = dp_out;
    out_data.status = s;
    if (s == ST_NO_E) begin
      out_data.public_exp = '0; out_data.private_exp = '0;
      out_data.ciphertext = '0; out_data.recovered = '0;
    end else if (s == ST_NO_D) begin
      out_data.private_exp = '0; out_data.recovered = '0;
    end
  end
  assign out_valid = fin;

  `ASSERT_IMPL(a_status_range, clk, rst_n, out_valid, out_data.status != 2'd3)
  `ASSERT_IMPL(a_valid_idle, clk, rst_n, out_valid, !busy)
  `ASSERT_IMPL(a_ok_has_exp, clk, rst_n, out_valid && out_data.status == ST_OK,
               out_data.public_exp != '0)
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import rsa_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int RANDOM_BEATS = 100;
  localparam int DRAIN_CYCLES = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rsa_in_t in_data = '0;
  logic out_valid;
  rsa_out_t out_data;

  rsa_out_t key_queue[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int received = 0;
  int status_seen[3] = '{0, 0, 0};
  int idle_pct = 0;

  typedef struct {
    logic [15:0] p;
    logic [15:0] q;
    logic [31:0] msg;
    bit typed;
    rsa_out_t want;
  } vector_t;

  vector_t vectors[$];

  toy_rsa_key_and_cipher dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] pow_under(longint unsigned b, longint unsigned x,
                                            longint unsigned m);
    longint unsigned acc;
    if (m == 0) return '0;
    acc = 1 % m;
    b = b % m;
    while (x != 0) begin
      if (x[0]) acc = (acc * b) % m;
      b = (b * b) % m;
      x = x >> 1;
    end
    return acc[31:0];
  endfunction

  function automatic longint unsigned inverse_under(longint e, longint t);
    longint r0, r1, s0, s1, qt, rn, sn;
    r0 = t; r1 = e; s0 = 0; s1 = 1;
    while (r1 != 0) begin
      qt = r0 / r1;
      rn = r0 - qt * r1;
      sn = s0 - qt * s1;
      r0 = r1; r1 = rn; s0 = s1; s1 = sn;
    end
    if (r0 != 1) return 0;
    s0 = s0 % t;
    if (s0 < 0) s0 += t;
    return s0;
  endfunction

  function automatic rsa_out_t derive_keys(rsa_in_t x);
    rsa_out_t r;
    logic [15:0] pm, qm;
    longint unsigned n, t, e, d;
    r = '0;
    pm = x.prime_p - 16'd1;
    qm = x.prime_q - 16'd1;
    n = longint'(x.prime_p) * longint'(x.prime_q);
    t = longint'(pm) * longint'(qm);
    e = 0;
    if (t >= 3)
      for (longint unsigned j = 2; j < t; j++)
        if (t % j != 0) begin
          e = j;
          break;
        end
    r.modulus = n[31:0];
    if (e == 0) begin
      r.status = ST_NO_E;
      return r;
    end
    r.public_exp = e[31:0];
    r.ciphertext = pow_under(x.message, e, n);
    d = inverse_under(e, t);
    if (d == 0) begin
      r.status = ST_NO_D;
    end else begin
      r.status = ST_OK;
      r.private_exp = d[31:0];
      r.recovered = pow_under(r.ciphertext, d, n);
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on beat %0d: %s got %0h want %0h", received, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsa_out_t w;
    if (rst_n && out_valid) begin
      if (key_queue.size() == 0) begin
        $display("unexpected result beat");
        errors++;
      end else begin
        w = key_queue.pop_front();
        if (out_data.modulus !== w.modulus) report("modulus", out_data.modulus, w.modulus);
        if (out_data.public_exp !== w.public_exp)
          report("public_exp", out_data.public_exp, w.public_exp);
        if (out_data.private_exp !== w.private_exp)
          report("private_exp", out_data.private_exp, w.private_exp);
        if (out_data.ciphertext !== w.ciphertext)
          report("ciphertext", out_data.ciphertext, w.ciphertext);
        if (out_data.recovered !== w.recovered)
          report("recovered", out_data.recovered, w.recovered);
        if (out_data.status !== w.status) report("status", out_data.status, w.status);
        if (w.status <= ST_NO_D) status_seen[w.status]++;
      end
      received++;
    end
  end

  task automatic send(rsa_in_t x, bit typed, rsa_out_t want);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (busy);
    key_queue.push_back(typed ? want : derive_keys(x));
    sent++;
    @(negedge clk);
  endtask

  function automatic rsa_out_t keys_of(logic [31:0] n, logic [31:0] e, logic [31:0] d,
                                       logic [31:0] c, logic [31:0] r, logic [1:0] s);
    rsa_out_t o;
    o.modulus = n; o.public_exp = e; o.private_exp = d;
    o.ciphertext = c; o.recovered = r; o.status = s;
    return o;
  endfunction

  function automatic void add_row(logic [15:0] p, logic [15:0] q, logic [31:0] m,
                                  bit typed, rsa_out_t want);
    vector_t v;
    v.p = p; v.q = q; v.msg = m; v.typed = typed; v.want = want;
    vectors.push_back(v);
  endfunction

  initial begin
    rsa_in_t x;
    int drain;
    // small totient, wrapped factors, extremes of every field
    add_row(16'd1, 16'd1, 32'd5, 1, keys_of(32'd1, 0, 0, 0, 0, ST_NO_E));
    add_row(16'hFFFF, 16'd1, 32'hFFFFFFFF, 1, keys_of(32'd65535, 0, 0, 0, 0, ST_NO_E));
    add_row(16'd1, 16'hFFFF, 32'hFFFFFFFF, 1, keys_of(32'd65535, 0, 0, 0, 0, ST_NO_E));
    add_row(16'd0, 16'd1, 32'd9, 1, keys_of(32'd0, 0, 0, 0, 0, ST_NO_E));
    add_row(16'd1, 16'd0, 32'd0, 1, keys_of(32'd0, 0, 0, 0, 0, ST_NO_E));
    add_row(16'd2, 16'd2, 32'd3, 1, keys_of(32'd4, 0, 0, 0, 0, ST_NO_E));
    // no inverse, then further rows; the untyped ones are checked against derive_keys
    add_row(16'd3, 16'd4, 32'd5, 1, keys_of(32'd12, 32'd4, 0, 32'd1, 0, ST_NO_D));
    add_row(16'd3, 16'd5, 32'd7, 1, keys_of(32'd15, 32'd3, 32'd3, 32'd13, 32'd7, ST_OK));
    add_row(16'd5, 16'd7, 32'hFFFFFFFF, 0, '0);
    add_row(16'd5, 16'd7, 32'd0, 0, '0);
    add_row(16'd11, 16'd13, 32'd100, 0, '0);
    add_row(16'd2, 16'd3, 32'h80000000, 0, '0);
    add_row(16'd7, 16'd2, 32'd13, 0, '0);
    add_row(16'd61, 16'd53, 32'd65, 0, '0);
    add_row(16'd17, 16'd13, 32'h5555AAAA, 0, '0);
    // modulus zero with a full key
    add_row(16'd0, 16'd0, 32'd77, 0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (vectors[i]) begin
      x.prime_p = vectors[i].p;
      x.prime_q = vectors[i].q;
      x.message = vectors[i].msg;
      send(x, vectors[i].typed, vectors[i].want);
    end
    start <= 1'b0;
    while (key_queue.size() != 0) @(negedge clk);

    for (int k = 0; k < RANDOM_BEATS; k++) begin
      case ((k / 25) % 4)
        0: idle_pct = 0;
        1: idle_pct = 49;
        2: idle_pct = 10;
        default: idle_pct = (k % 2) ? 49 : 0;
      endcase
      x.message = $urandom();
      case ($urandom_range(9))
        0: begin
          x.prime_p = 16'($urandom());
          x.prime_q = 16'd1;
        end
        1: begin
          x.prime_p = 16'd1;
          x.prime_q = 16'($urandom());
        end
        default: begin
          x.prime_p = 16'($urandom_range(17, 1));
          x.prime_q = 16'($urandom_range(17, 1));
        end
      endcase
      send(x, 0, '0);
      if (k == RANDOM_BEATS / 2) begin
        start <= 1'b0;
        while (key_queue.size() != 0) @(negedge clk);
      end
    end

    start <= 1'b0;
    while (key_queue.size() != 0) @(negedge clk);
    drain = 0;
    while (drain < DRAIN_CYCLES && key_queue.size() == 0) begin
      @(negedge clk);
      drain++;
    end
    if (key_queue.size() == 0) drain = 0;
    while (key_queue.size() != 0) @(negedge clk);

    $display("sent %0d key setups, checked %0d results", sent, received);
    $display("status mix: ok %0d, no public exponent %0d, no private exponent %0d",
             status_seen[0], status_seen[1], status_seen[2]);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
